FILE: rtl/sobel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge stream package
// Shared constants, payload types and codes for the Sobel edge magnitude
// stream and its submodules.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned HeightLimit  = 1024;
  localparam int unsigned MinDim       = 3;
  localparam int unsigned DimReset     = 400;

  localparam int unsigned PixW         = 8;
  localparam int unsigned ColW         = $clog2(MaxWidth);
  localparam int unsigned RowW         = $clog2(HeightLimit);
  localparam int unsigned OutColW      = 10;
  localparam int unsigned OutRowW      = 10;
  localparam int unsigned GradW        = PixW + 3;
  localparam int unsigned SqW          = 2 * GradW - 1;
  localparam int unsigned MagW         = 11;

  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 11;

  localparam int unsigned LumaW        = PixW + 4;
  localparam int unsigned GrayMul      = 3277;
  localparam int unsigned GrayShift    = 15;
  localparam int unsigned GrayProdW    = 2 * LumaW;

  localparam int unsigned QDepth       = 4;
  localparam int unsigned QIdxW        = $clog2(QDepth);
  localparam int unsigned QCntW        = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BkIdle = 3'b001,
    BkRoot = 3'b010,
    BkOut  = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [OutRowW-1:0] center_row;
    logic [OutColW-1:0] center_column;
    logic [MagW-1:0]    gradient_magnitude;
    logic               frame_done;
  } result_t;

  typedef struct packed {
    logic [OutRowW-1:0]      row;
    logic [OutColW-1:0]      col;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic                    done;
  } grad_t;

  function automatic logic [31:0] sat_dim(logic [CfgDataW-1:0] v, int unsigned hi);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 < 32'(MinDim)) begin
      return 32'(MinDim);
    end else if (v32 > 32'(hi)) begin
      return 32'(hi);
    end
    return v32;
  endfunction

endpackage

FILE: rtl/sobel_edge_magnitude_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude stream
// Top level: gray conversion, 3x3 Sobel window and gradient magnitude for a
// raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel in raster order, one transaction per pixel.
// Each interior pixel of the frame yields one transaction on the out channel
// with its row, column, floored gradient magnitude and a flag on the last
// interior pixel of the frame. Border pixels yield nothing.
// The front takes one pixel per cycle while the four-entry gradient queue
// has room. For each result the back loads the squared gradients, runs 11
// square-root steps of one result bit each, and then shows the result
// until it is taken; it takes no new gradient pair before then, so interior
// pixels back up in the queue; border pixels pass at one per cycle while
// the queue has room. A result follows the pixel below and to the right of
// its center through the window register, the queue and the root steps.
// Writing either register restarts the frame at row 0, column 0; write only
// while the block is idle. Reset sets both sizes to 400 and restarts the
// frame; the line stores hold no meaningful data until two rows have passed.
// A stalled result holds on the out channel, and the input stalls once the
// queued pairs plus the pixel held in the window register fill the queue.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sobel_pkg::pixel_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sobel_pkg::result_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sobel_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sobel_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sobel_pkg::*;

  logic              push;
  grad_t             push_data;
  logic              q_valid;
  grad_t             q_data;
  logic              q_pop;
  logic [QCntW-1:0]  q_count;

  sobel_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sobel_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  sobel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/sobel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sobel_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient queue
// Short FIFO of gradient pairs between the window front and the root back.
// ----------------------------------------------------------------------------
module sobel_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  sobel_pkg::grad_t                push_data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output sobel_pkg::grad_t                data_o,
  output logic [sobel_pkg::QCntW-1:0]     count_o
);
  import sobel_pkg::*;

  grad_t             mem_q [QDepth];
  logic [QIdxW-1:0]  wptr_q, wptr_d;
  logic [QIdxW-1:0]  rptr_q, rptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = wptr_q + QIdxW'(1);
    end
    if (do_pop) begin
      rptr_d = rptr_q + QIdxW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/sobel_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel window front
// Accepts pixels, converts them to gray, keeps the line stores and the 3x3
// window, and queues the Sobel gradients of every interior center.
// ----------------------------------------------------------------------------
module sobel_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sobel_pkg::pixel_t               in_data_i,
  input  logic                            cfg_we_i,
  input  logic [sobel_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sobel_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [sobel_pkg::QCntW-1:0]     q_count_i,
  output logic                            push_o,
  output sobel_pkg::grad_t                push_data_o
);
  import sobel_pkg::*;

  logic                  accept;
  logic [LumaW-1:0]      luma_sum;
  logic [GrayProdW-1:0]  gray_prod;
  logic [PixW-1:0]       gray;

  logic [ColW-1:0]       wlast_q, wlast_d;
  logic [RowW-1:0]       hlast_q, hlast_d;
  logic                  cfg_hit;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;

  logic                  b_valid_q;
  logic [ColW-1:0]       b_col_q;
  logic [RowW-1:0]       b_row_q;
  logic [PixW-1:0]       b_gray_q;
  logic [PixW-1:0]       win_q [6];

  logic [PixW-1:0]       upper_rd;
  logic [PixW-1:0]       middle_rd;
  logic [PixW+1:0]       sum_left, sum_right, sum_top, sum_bottom;

  function automatic logic [PixW+1:0] tap_sum(logic [PixW-1:0] a, logic [PixW-1:0] b,
                                               logic [PixW-1:0] c);
    return (PixW+2)'(a) + (PixW+2)'({b, 1'b0}) + (PixW+2)'(c);
  endfunction

  assign in_stall_o = (q_count_i + QCntW'(b_valid_q)) >= QCntW'(QDepth);
  assign accept     = in_valid_i & ~in_stall_o;

  assign luma_sum  = LumaW'({in_data_i.red, 1'b0}) + LumaW'({in_data_i.green, 3'b000})
                   - LumaW'(in_data_i.green) + LumaW'(in_data_i.blue);
  assign gray_prod = GrayProdW'(luma_sum) * GrayProdW'(GrayMul);
  assign gray      = gray_prod[GrayShift +: PixW];

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegImageWidth: begin
          wlast_d = ColW'(sat_dim(cfg_data_i, MaxWidth) - 32'd1);
          cfg_hit = 1'b1;
        end
        RegImageHeight: begin
          hlast_d = RowW'(sat_dim(cfg_data_i, HeightLimit) - 32'd1);
          cfg_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q   <= ColW'(DimReset - 1);
      hlast_q   <= RowW'(DimReset - 1);
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      wlast_q   <= wlast_d;
      hlast_q   <= hlast_d;
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q  <= col_q;
      b_row_q  <= row_q;
      b_gray_q <= gray;
    end
    if (b_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= upper_rd;
      win_q[4] <= middle_rd;
      win_q[5] <= b_gray_q;
    end
  end

  sobel_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (middle_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (upper_rd)
  );

  sobel_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (b_gray_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (middle_rd)
  );

  assign sum_left   = tap_sum(win_q[0], win_q[1], win_q[2]);
  assign sum_right  = tap_sum(upper_rd, middle_rd, b_gray_q);
  assign sum_top    = tap_sum(win_q[0], win_q[3], upper_rd);
  assign sum_bottom = tap_sum(win_q[2], win_q[5], b_gray_q);

  assign push_o = b_valid_q && (b_row_q >= RowW'(2)) && (b_col_q >= ColW'(2));

  always_comb begin
    push_data_o.row  = OutRowW'(b_row_q - RowW'(1));
    push_data_o.col  = OutColW'(b_col_q - ColW'(1));
    push_data_o.gx   = $signed(GradW'(sum_left)) - $signed(GradW'(sum_right));
    push_data_o.gy   = $signed(GradW'(sum_bottom)) - $signed(GradW'(sum_top));
    push_data_o.done = (b_row_q == hlast_q) && (b_col_q == wlast_q);
  end

endmodule

FILE: rtl/sobel_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel magnitude back
// Takes gradient pairs from the queue, squares and sums them, and finds the
// integer square root one result bit per cycle.
// ----------------------------------------------------------------------------
module sobel_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sobel_pkg::grad_t   q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sobel_pkg::result_t out_data_o
);
  import sobel_pkg::*;

  localparam logic [SqW-1:0] TopBit = SqW'(1) << (SqW - 1);

  back_state_e              state_q, state_d;
  logic [SqW-1:0]           v_q, v_d;
  logic [SqW-1:0]           res_q, res_d;
  logic [SqW-1:0]           bit_q, bit_d;
  grad_t                    ctx_q;
  logic signed [2*GradW-1:0] gx_sq, gy_sq;
  logic [SqW:0]             trial;

  assign gx_sq = $signed(q_data_i.gx) * $signed(q_data_i.gx);
  assign gy_sq = $signed(q_data_i.gy) * $signed(q_data_i.gy);
  assign trial = (SqW+1)'(res_q) + (SqW+1)'(bit_q);

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    res_d   = res_q;
    bit_d   = bit_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          v_d     = SqW'($unsigned(gx_sq)) + SqW'($unsigned(gy_sq));
          res_d   = '0;
          bit_d   = TopBit;
          state_d = BkRoot;
        end
      end
      BkRoot: begin
        if ((SqW+1)'(v_q) >= trial) begin
          v_d   = v_q - SqW'(trial);
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = BkOut;
        end
      end
      BkOut: begin
        if (!out_stall_i) begin
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
    if (q_pop_o) begin
      ctx_q <= q_data_i;
    end
  end

  assign out_valid_o = (state_q == BkOut);

  always_comb begin
    out_data_o.center_row         = ctx_q.row;
    out_data_o.center_column      = ctx_q.col;
    out_data_o.gradient_magnitude = res_q[MagW-1:0];
    out_data_o.frame_done         = ctx_q.done;
  end

endmodule

FILE: rtl/sobel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel port checker
// Concurrent checks on the out channel of the Sobel edge magnitude stream.
// ----------------------------------------------------------------------------
module sobel_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  sobel_pkg::result_t out_data_o
);
  import sobel_pkg::*;

  localparam logic [MagW-1:0] MagMax = MagW'(1442);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed or was dropped.");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.center_row != '0) && (out_data_o.center_column != '0))
    else $error("Result reported for a border pixel.");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gradient_magnitude <= MagMax)
    else $error("Gradient magnitude out of range.");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("Result shown during reset.");

endmodule

bind sobel_edge_magnitude_stream sobel_checker u_sobel_checker (.*);
